FILE: rtl/bbts_pkg.sv
// ----------------------------------------------------------------------------
// bbts_pkg
// shared types and constants of the balanced bucket tick scheduler
// ----------------------------------------------------------------------------
package bbts_pkg;

  localparam int DEF_NUM_BUCKETS  = 8;
  localparam int DEF_BUCKET_DEPTH = 32;
  localparam int HANDLE_BITS      = 16;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 5;

  typedef enum logic [1:0] {
    FN_REG   = 2'd0,
    FN_UNREG = 2'd1,
    FN_TICK  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    KD_PLACED     = 3'd0,
    KD_REMOVED    = 3'd1,
    KD_MOVED      = 3'd2,
    KD_TICK_ENTRY = 3'd3,
    KD_TICK_EMPTY = 3'd4,
    KD_ERROR      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ER_NONE     = 2'd0,
    ER_FULL     = 2'd1,
    ER_RANGE    = 2'd2,
    ER_MISMATCH = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TICK
  } state_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

endpackage

FILE: rtl/bbts_store.sv
// ----------------------------------------------------------------------------
// bbts_store
// handle store: one write port, two registered read ports sharing an enable
// ----------------------------------------------------------------------------
module bbts_store #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_a_r;
  logic [DATA_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

FILE: rtl/bbts_counts.sv
// ----------------------------------------------------------------------------
// bbts_counts
// per-bucket fill counts with least-loaded search and one update per cycle
// ----------------------------------------------------------------------------
module bbts_counts #(
  parameter int NUM_BUCKETS = 8,
  parameter int BKT_W       = 3,
  parameter int CNT_W       = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bbts_pkg::cnt_op_t       upd_op,
  input  logic [BKT_W-1:0]        upd_idx,
  input  logic [BKT_W-1:0]        rd_idx,
  output logic [CNT_W-1:0]        rd_cnt,
  output logic [BKT_W-1:0]        best_idx,
  output logic [CNT_W-1:0]        best_cnt
);

  import bbts_pkg::*;

  localparam int IDX_XW = BKT_W + 1;

  logic [CNT_W-1:0] cnt_r [NUM_BUCKETS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      case (upd_op)
        CNT_INC: cnt_r[upd_idx] <= CNT_W'(cnt_r[upd_idx] + CNT_W'(1));
        CNT_DEC: cnt_r[upd_idx] <= CNT_W'(cnt_r[upd_idx] - CNT_W'(1));
        default: ;
      endcase
    end
  end

  // out-of-range bucket reads as empty
  assign rd_cnt = (IDX_XW'(rd_idx) < IDX_XW'(NUM_BUCKETS)) ? cnt_r[rd_idx] : '0;

  // least loaded, lowest index on a tie
  always_comb begin
    best_idx = '0;
    best_cnt = cnt_r[0];
    for (int i = 1; i < NUM_BUCKETS; i++) begin
      if (cnt_r[i] < best_cnt) begin
        best_idx = BKT_W'(i);
        best_cnt = cnt_r[i];
      end
    end
  end

endmodule

FILE: rtl/balanced_bucket_tick_scheduler.sv
// ----------------------------------------------------------------------------
// balanced_bucket_tick_scheduler
// spreads entry handles over time-slot buckets and walks one bucket per tick
// ----------------------------------------------------------------------------
// A register or unregister word issues both store reads in the cycle it is
// accepted; the result is formed and the store and count are written back
// in the execute state. A tick word is accepted with a read of the first
// slot of the next bucket, then gives one result per handle in the bucket
// (one empty-tick result if the bucket is empty); the handle store is
// read one slot ahead of the result being emitted. Each word is finished
// before the next is accepted; a word may be accepted while the previous
// result still sits in the output register. Stalls on the output side hold
// the execute or tick state. A func code of 3 is consumed with no result.
// The store holds no reset value; reads of slots at or above a bucket's
// count may be issued, but their data is never used.
// ----------------------------------------------------------------------------
module balanced_bucket_tick_scheduler #(
  parameter int NUM_BUCKETS  = bbts_pkg::DEF_NUM_BUCKETS,
  parameter int BUCKET_DEPTH = bbts_pkg::DEF_BUCKET_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // entry_id[15:0], bucket_sel[18:16], slot_sel[23:19]
  input  logic [bbts_pkg::IN_DATA_W-1:0]      in_tdata,
  // func[1:0]
  input  logic [bbts_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // bucket_out[2:0], slot_out[7:3], handle_out[23:8]
  output logic [bbts_pkg::OUT_DATA_W-1:0]     out_tdata,
  // kind[2:0], error_code[4:3]
  output logic [bbts_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast
);

  import bbts_pkg::*;

  localparam int BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SLOT_W  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int CNT_W   = $clog2(BUCKET_DEPTH + 1);
  localparam int MEM_D   = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int ADDR_W  = (MEM_D > 1) ? $clog2(MEM_D) : 1;
  localparam int BX_W    = ((BKT_W > 3) ? BKT_W : 3) + 1;
  localparam int SX_W    = ((CNT_W > 5) ? CNT_W : 5) + 1;

  function automatic logic [ADDR_W-1:0] mk_addr(input logic [BKT_W-1:0]  b,
                                                input logic [SLOT_W-1:0] s);
    return ADDR_W'(ADDR_W'(b) * ADDR_W'(BUCKET_DEPTH) + ADDR_W'(s));
  endfunction

  // input word fields
  logic [HANDLE_BITS-1:0] in_id;
  logic [2:0]             in_bsel;
  logic [4:0]             in_ssel;
  logic [BKT_W-1:0]       in_bkt;

  assign in_id   = in_tdata[15:0];
  assign in_bsel = in_tdata[18:16];
  assign in_ssel = in_tdata[23:19];
  assign in_bkt  = BKT_W'(in_bsel);

  // held item
  func_t                  func_r;
  logic [HANDLE_BITS-1:0] id_r;
  logic [2:0]             bsel_r;
  logic [4:0]             ssel_r;
  logic [BKT_W-1:0]       bkt_q;

  assign bkt_q = BKT_W'(bsel_r);

  state_t           state_r, state_nxt;
  logic [BKT_W-1:0] cb_r, cb_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [BKT_W-1:0] next_bkt;

  assign next_bkt = (BX_W'(cb_r) == BX_W'(NUM_BUCKETS - 1)) ? '0 : BKT_W'(cb_r + 1'b1);

  // store and count interfaces
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [HANDLE_BITS-1:0] mem_wdata;
  logic                   mem_re;
  logic [ADDR_W-1:0]      mem_raddr_a;
  logic [ADDR_W-1:0]      mem_raddr_b;
  logic [HANDLE_BITS-1:0] mem_rdata_a;
  logic [HANDLE_BITS-1:0] mem_rdata_b;

  cnt_op_t          cnt_op;
  logic [BKT_W-1:0] cnt_upd_idx;
  logic [BKT_W-1:0] cnt_rd_idx;
  logic [CNT_W-1:0] cnt_rd;
  logic [BKT_W-1:0] best_idx;
  logic [CNT_W-1:0] best_cnt;

  bbts_store #(
    .DEPTH  (MEM_D),
    .ADDR_W (ADDR_W),
    .DATA_W (HANDLE_BITS)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  bbts_counts #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BKT_W       (BKT_W),
    .CNT_W       (CNT_W)
  ) u_counts (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_op   (cnt_op),
    .upd_idx  (cnt_upd_idx),
    .rd_idx   (cnt_rd_idx),
    .rd_cnt   (cnt_rd),
    .best_idx (best_idx),
    .best_cnt (best_cnt)
  );

  assign cnt_rd_idx = (state_r == S_IDLE) ? in_bkt :
                      (state_r == S_TICK) ? cb_r : bkt_q;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic                  out_last_r;
  logic                  out_free;

  assign out_free = !out_valid_r || out_tready;

  // unregister and tick checks
  logic             bsel_ok;
  logic             slot_ok;
  logic [CNT_W-1:0] last_slot;
  logic             is_last;
  logic             tick_last;

  assign bsel_ok   = BX_W'(bsel_r) < BX_W'(NUM_BUCKETS);
  assign slot_ok   = SX_W'(ssel_r) < SX_W'(cnt_rd);
  assign last_slot = CNT_W'(cnt_rd - CNT_W'(1));
  assign is_last   = SX_W'(ssel_r) == SX_W'(last_slot);
  assign tick_last = CNT_W'(CNT_W'(idx_r) + CNT_W'(1)) == cnt_rd;

  logic                   ld_item;
  logic                   res_load;
  kind_t                  res_kind;
  err_t                   res_err;
  logic [2:0]             res_bkt;
  logic [4:0]             res_slot;
  logic [HANDLE_BITS-1:0] res_handle;
  logic                   res_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cb_r    <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cb_r    <= cb_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_item) begin
      func_r <= func_t'(in_tuser);
      id_r   <= in_id;
      bsel_r <= in_bsel;
      ssel_r <= in_ssel;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cb_nxt      = cb_r;
    idx_nxt     = idx_r;
    in_tready   = 1'b0;
    ld_item     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr_a = '0;
    mem_raddr_b = '0;
    cnt_op      = CNT_HOLD;
    cnt_upd_idx = '0;
    res_load    = 1'b0;
    res_kind    = KD_PLACED;
    res_err     = ER_NONE;
    res_bkt     = '0;
    res_slot    = '0;
    res_handle  = '0;
    res_last    = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ld_item = 1'b1;
          case (func_t'(in_tuser))
            FN_REG, FN_UNREG: begin
              mem_re      = 1'b1;
              mem_raddr_a = mk_addr(in_bkt, SLOT_W'(in_ssel));
              mem_raddr_b = mk_addr(in_bkt, SLOT_W'(CNT_W'(cnt_rd - CNT_W'(1))));
              state_nxt   = S_EXEC;
            end
            FN_TICK: begin
              mem_re      = 1'b1;
              mem_raddr_a = mk_addr(next_bkt, '0);
              cb_nxt      = next_bkt;
              idx_nxt     = '0;
              state_nxt   = S_TICK;
            end
            default: ;
          endcase
        end
      end
      S_EXEC: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
          if (func_r == FN_REG) begin
            res_handle = id_r;
            if (best_cnt >= CNT_W'(BUCKET_DEPTH)) begin
              res_kind = KD_ERROR;
              res_err  = ER_FULL;
            end else begin
              mem_we      = 1'b1;
              mem_waddr   = mk_addr(best_idx, SLOT_W'(best_cnt));
              mem_wdata   = id_r;
              cnt_op      = CNT_INC;
              cnt_upd_idx = best_idx;
              res_kind    = KD_PLACED;
              res_bkt     = 3'(best_idx);
              res_slot    = 5'(best_cnt);
            end
          end else begin
            res_bkt    = bsel_r;
            res_slot   = ssel_r;
            res_handle = id_r;
            if (!(bsel_ok && slot_ok)) begin
              res_kind = KD_ERROR;
              res_err  = ER_RANGE;
            end else if (mem_rdata_a != id_r) begin
              res_kind = KD_ERROR;
              res_err  = ER_MISMATCH;
            end else begin
              cnt_op      = CNT_DEC;
              cnt_upd_idx = bkt_q;
              if (is_last) begin
                res_kind = KD_REMOVED;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = mk_addr(bkt_q, SLOT_W'(ssel_r));
                mem_wdata  = mem_rdata_b;
                res_kind   = KD_MOVED;
                res_handle = mem_rdata_b;
              end
            end
          end
        end
      end
      S_TICK: begin
        res_bkt = 3'(cb_r);
        if (out_free) begin
          res_load = 1'b1;
          if (cnt_rd == '0) begin
            res_kind  = KD_TICK_EMPTY;
            state_nxt = S_IDLE;
          end else begin
            res_kind   = KD_TICK_ENTRY;
            res_slot   = 5'(idx_r);
            res_handle = mem_rdata_a;
            res_last   = tick_last;
            if (tick_last) begin
              state_nxt = S_IDLE;
            end else begin
              // fetch the next slot while this word goes out
              mem_re      = 1'b1;
              mem_raddr_a = mk_addr(cb_r, SLOT_W'(idx_r + 1'b1));
              idx_nxt     = SLOT_W'(idx_r + 1'b1);
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= {res_handle, res_slot, res_bkt};
      out_user_r <= {res_err, res_kind};
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // checks

  a_write_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_EXEC) && out_free)
    else $error("store written outside a result cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    best_cnt <= CNT_W'(BUCKET_DEPTH))
    else $error("bucket count above depth");

  a_tick_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK) && (cnt_rd != '0) |-> CNT_W'(idx_r) < cnt_rd)
    else $error("tick walk past bucket fill");

  a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FN_REG || in_tuser == FN_UNREG)
    |=> state_r == S_EXEC)
    else $error("register or unregister word did not enter execute");

endmodule
